// ===== src/kst_pkg.sv =====
// shared constants and types for the kelvin tensor inverse
`timescale 1ns / 1ps
package kst_pkg;

    localparam int FRAC_BITS_DEF  = 16;
    localparam int DATA_WIDTH_DEF = 32;
    localparam int COMP_W         = 32;
    localparam int DET_W          = 64;
    localparam int NUM_COMP       = 6;

    // sqrt(2)/2 in Q0.32, rounded half up
    localparam logic signed [32:0] HALF_ROOT2_Q32 = 33'sd3037000500;

    typedef struct packed {
        logic                singular;
        logic                det_sat;
        logic [NUM_COMP-1:0] ovf;
        logic [NUM_COMP-1:0] neg;
    } kst_flags_t;

endpackage

// ===== src/kst_if.sv =====
// valid/ready channels for tensor beats and result beats
`timescale 1ns / 1ps
interface kst_in_if;
    import kst_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [COMP_W-1:0] comp_0;
    logic signed [COMP_W-1:0] comp_1;
    logic signed [COMP_W-1:0] comp_2;
    logic signed [COMP_W-1:0] comp_3;
    logic signed [COMP_W-1:0] comp_4;
    logic signed [COMP_W-1:0] comp_5;

    modport source (output valid, comp_0, comp_1, comp_2, comp_3, comp_4, comp_5,
                    input ready);
    modport sink (input valid, comp_0, comp_1, comp_2, comp_3, comp_4, comp_5,
                  output ready);
endinterface

interface kst_out_if;
    import kst_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [COMP_W-1:0] inv_0;
    logic signed [COMP_W-1:0] inv_1;
    logic signed [COMP_W-1:0] inv_2;
    logic signed [COMP_W-1:0] inv_3;
    logic signed [COMP_W-1:0] inv_4;
    logic signed [COMP_W-1:0] inv_5;
    logic signed [DET_W-1:0]  det_value;
    logic                     singular;
    logic                     saturated;

    modport source (output valid, inv_0, inv_1, inv_2, inv_3, inv_4, inv_5, det_value,
                    singular, saturated, input ready);
    modport sink (input valid, inv_0, inv_1, inv_2, inv_3, inv_4, inv_5, det_value,
                  singular, saturated, output ready);
endinterface

// ===== src/kst_front.sv =====
// product pipeline: determinant and doubled adjugate terms
`timescale 1ns / 1ps
module kst_front #(
    parameter int W = kst_pkg::COMP_W,
    parameter int F = kst_pkg::FRAC_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         plane_mode,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic signed [W-1:0]          comp [kst_pkg::NUM_COMP],
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic signed [3*W+3-F:0]      det,
    output logic signed [2*W+1:0]        adj [kst_pkg::NUM_COMP]
);
    import kst_pkg::*;

    localparam int NS  = 6;
    localparam int PW  = 2 * W;
    localparam int AW  = 2 * W + 2;
    localparam int TW  = 3 * W + 2;
    localparam int SW  = 3 * W + 5;
    localparam int RW  = 2 * W + 34;
    localparam int DTW = 3 * W + 4 - F;
    localparam logic signed [RW-1:0] ROUND_R = RW'(1) <<< 31;
    localparam logic signed [SW-1:0] ROUND_D = SW'(1) <<< F;

    logic [NS-1:0] vld_reg;
    logic [NS-1:0] en;

    // stage 0
    logic signed [W-1:0]    v_reg [NUM_COMP];
    // stage 1
    logic signed [PW-1:0]   p01_reg, p02_reg, p12_reg, p33_reg, p44_reg, p55_reg;
    logic signed [PW-1:0]   p34_reg, p45_reg, p35_reg, p32_reg, p40_reg, p15_reg;
    logic signed [W-1:0]    s1v0_reg, s1v1_reg, s1v2_reg, s1v5_reg;
    // stage 2
    logic signed [W+32:0]   rh34_reg, rh45_reg, rh35_reg;
    logic signed [W+33:0]   rl34_reg, rl45_reg, rl35_reg;
    logic signed [PW-1:0]   dh012_reg, dh33_reg, dh44_reg, dh55_reg;
    logic signed [PW:0]     dl012_reg, dl33_reg, dl44_reg, dl55_reg;
    logic signed [AW-1:0]   s2a0_reg, s2a1_reg, s2a2_reg;
    logic signed [PW-1:0]   s2p32_reg, s2p40_reg, s2p15_reg;
    logic signed [W-1:0]    s2v5_reg;
    // stage 3
    logic signed [PW-1:0]   r34_reg, r45_reg, r35_reg;
    logic signed [TW-1:0]   t012_reg, t33_reg, t44_reg, t55_reg;
    logic signed [AW-1:0]   s3a0_reg, s3a1_reg, s3a2_reg;
    logic signed [PW-1:0]   s3p32_reg, s3p40_reg, s3p15_reg;
    logic signed [W-1:0]    s3v5_reg;
    // stage 4
    logic signed [PW-1:0]   eh_reg;
    logic signed [PW:0]     el_reg;
    logic signed [SW-1:0]   sa_reg;
    logic signed [AW-1:0]   s4adj_reg [NUM_COMP];
    // stage 5
    logic signed [DTW-1:0]  det_reg;
    logic signed [AW-1:0]   adj_reg [NUM_COMP];

    logic signed [RW-1:0]   r34_sum, r45_sum, r35_sum;
    logic signed [SW-1:0]   s_sum;

    always_comb
    begin
        en[NS-1] = !vld_reg[NS-1] || out_ready;
        for (int k = NS - 2; k >= 0; k--)
        begin
            en[k] = !vld_reg[k] || en[k+1];
        end
    end

    assign in_ready  = en[0];
    assign out_valid = vld_reg[NS-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                vld_reg[0] <= in_valid;
            end
            for (int k = 1; k < NS; k++)
            begin
                if (en[k])
                begin
                    vld_reg[k] <= vld_reg[k-1];
                end
            end
        end
    end

    assign r34_sum = (RW'(rh34_reg) <<< W) + RW'(rl34_reg) + ROUND_R;
    assign r45_sum = (RW'(rh45_reg) <<< W) + RW'(rl45_reg) + ROUND_R;
    assign r35_sum = (RW'(rh35_reg) <<< W) + RW'(rl35_reg) + ROUND_R;
    assign s_sum   = sa_reg + (SW'(eh_reg) <<< (W + 1)) + (SW'(el_reg) <<< 1) + ROUND_D;

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            for (int i = 0; i < 4; i++)
            begin
                v_reg[i] <= comp[i];
            end
            // plane form drops the yz and xz terms
            v_reg[4] <= plane_mode ? '0 : comp[4];
            v_reg[5] <= plane_mode ? '0 : comp[5];
        end
        if (en[1])
        begin
            p01_reg  <= v_reg[0] * v_reg[1];
            p02_reg  <= v_reg[0] * v_reg[2];
            p12_reg  <= v_reg[1] * v_reg[2];
            p33_reg  <= v_reg[3] * v_reg[3];
            p44_reg  <= v_reg[4] * v_reg[4];
            p55_reg  <= v_reg[5] * v_reg[5];
            p34_reg  <= v_reg[3] * v_reg[4];
            p45_reg  <= v_reg[4] * v_reg[5];
            p35_reg  <= v_reg[3] * v_reg[5];
            p32_reg  <= v_reg[3] * v_reg[2];
            p40_reg  <= v_reg[4] * v_reg[0];
            p15_reg  <= v_reg[1] * v_reg[5];
            s1v0_reg <= v_reg[0];
            s1v1_reg <= v_reg[1];
            s1v2_reg <= v_reg[2];
            s1v5_reg <= v_reg[5];
        end
        if (en[2])
        begin
            // 2W x 33 products split into signed high and unsigned low halves
            rh34_reg  <= $signed(p34_reg[PW-1:W]) * HALF_ROOT2_Q32;
            rl34_reg  <= $signed({1'b0, p34_reg[W-1:0]}) * HALF_ROOT2_Q32;
            rh45_reg  <= $signed(p45_reg[PW-1:W]) * HALF_ROOT2_Q32;
            rl45_reg  <= $signed({1'b0, p45_reg[W-1:0]}) * HALF_ROOT2_Q32;
            rh35_reg  <= $signed(p35_reg[PW-1:W]) * HALF_ROOT2_Q32;
            rl35_reg  <= $signed({1'b0, p35_reg[W-1:0]}) * HALF_ROOT2_Q32;
            dh012_reg <= $signed(p01_reg[PW-1:W]) * s1v2_reg;
            dl012_reg <= $signed({1'b0, p01_reg[W-1:0]}) * s1v2_reg;
            dh33_reg  <= $signed(p33_reg[PW-1:W]) * s1v2_reg;
            dl33_reg  <= $signed({1'b0, p33_reg[W-1:0]}) * s1v2_reg;
            dh44_reg  <= $signed(p44_reg[PW-1:W]) * s1v0_reg;
            dl44_reg  <= $signed({1'b0, p44_reg[W-1:0]}) * s1v0_reg;
            dh55_reg  <= $signed(p55_reg[PW-1:W]) * s1v1_reg;
            dl55_reg  <= $signed({1'b0, p55_reg[W-1:0]}) * s1v1_reg;
            s2a0_reg  <= (AW'(p12_reg) <<< 1) - AW'(p44_reg);
            s2a1_reg  <= (AW'(p02_reg) <<< 1) - AW'(p55_reg);
            s2a2_reg  <= (AW'(p01_reg) <<< 1) - AW'(p33_reg);
            s2p32_reg <= p32_reg;
            s2p40_reg <= p40_reg;
            s2p15_reg <= p15_reg;
            s2v5_reg  <= s1v5_reg;
        end
        if (en[3])
        begin
            r34_reg   <= r34_sum[PW+31:32];
            r45_reg   <= r45_sum[PW+31:32];
            r35_reg   <= r35_sum[PW+31:32];
            t012_reg  <= (TW'(dh012_reg) <<< W) + TW'(dl012_reg);
            t33_reg   <= (TW'(dh33_reg) <<< W) + TW'(dl33_reg);
            t44_reg   <= (TW'(dh44_reg) <<< W) + TW'(dl44_reg);
            t55_reg   <= (TW'(dh55_reg) <<< W) + TW'(dl55_reg);
            s3a0_reg  <= s2a0_reg;
            s3a1_reg  <= s2a1_reg;
            s3a2_reg  <= s2a2_reg;
            s3p32_reg <= s2p32_reg;
            s3p40_reg <= s2p40_reg;
            s3p15_reg <= s2p15_reg;
            s3v5_reg  <= s2v5_reg;
        end
        if (en[4])
        begin
            eh_reg       <= $signed(r34_reg[PW-1:W]) * s3v5_reg;
            el_reg       <= $signed({1'b0, r34_reg[W-1:0]}) * s3v5_reg;
            sa_reg       <= (SW'(t012_reg) <<< 1) - SW'(t33_reg) - SW'(t44_reg)
                            - SW'(t55_reg);
            s4adj_reg[0] <= s3a0_reg;
            s4adj_reg[1] <= s3a1_reg;
            s4adj_reg[2] <= s3a2_reg;
            s4adj_reg[3] <= (AW'(r45_reg) <<< 1) - (AW'(s3p32_reg) <<< 1);
            s4adj_reg[4] <= (AW'(r35_reg) <<< 1) - (AW'(s3p40_reg) <<< 1);
            s4adj_reg[5] <= (AW'(r34_reg) <<< 1) - (AW'(s3p15_reg) <<< 1);
        end
        if (en[5])
        begin
            // twice the determinant at 3F fraction bits, back to 2F with rounding
            det_reg <= DTW'(s_sum >>> (F + 1));
            for (int i = 0; i < NUM_COMP; i++)
            begin
                adj_reg[i] <= s4adj_reg[i];
            end
        end
    end

    assign det = det_reg;
    always_comb
    begin
        for (int i = 0; i < NUM_COMP; i++)
        begin
            adj[i] = adj_reg[i];
        end
    end

endmodule

// ===== src/kst_divider.sv =====
// pipelined restoring divider, six lanes sharing one divisor
`timescale 1ns / 1ps
module kst_divider #(
    parameter int W = kst_pkg::COMP_W,
    parameter int F = kst_pkg::FRAC_BITS_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic signed [3*W+3-F:0]    det,
    input  logic signed [2*W+1:0]      adj [kst_pkg::NUM_COMP],
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [W-1:0]               quot [kst_pkg::NUM_COMP],
    output kst_pkg::kst_flags_t        flags,
    output logic [kst_pkg::DET_W-1:0]  det_out
);
    import kst_pkg::*;

    localparam int AW  = 2 * W + 2;
    localparam int DTW = 3 * W + 4 - F;
    localparam int DDW = DTW + 1;
    localparam int NW  = ((AW + F > DTW) ? AW + F : DTW) + 1;
    localparam int CW  = (NW - W > DDW) ? NW - W : DDW;
    localparam int EW  = (DTW > DET_W) ? DTW : DET_W + 1;
    localparam int NS  = W + 3;

    logic [NS-1:0] vld_reg;
    logic [NS-1:0] en;

    kst_flags_t         fl_reg    [NS];
    logic [DET_W-1:0]   det64_reg [NS];

    logic [DTW-1:0]     ad_reg;
    logic [AW-1:0]      an_reg  [NUM_COMP];
    logic [DDW-1:0]     d1_reg;
    logic [NW-1:0]      n_reg   [NUM_COMP];

    // index 0 is the setup stage, index j+1 follows division step j
    logic [DDW-1:0]     d_reg   [W+1];
    logic [DDW-1:0]     rem_reg [W+1][NUM_COMP];
    logic [W-1:0]       nlo_reg [W+1][NUM_COMP];
    logic [W-1:0]       q_reg   [W+1][NUM_COMP];

    logic [DDW-1:0]     rem_nx  [W][NUM_COMP];
    logic [W-1:0]       q_nx    [W][NUM_COMP];

    logic [EW-1:0]      det_x;
    logic               det_fits;
    logic [DTW-1:0]     ad_nx;
    logic [AW-1:0]      an_nx   [NUM_COMP];
    logic [CW-1:0]      nhi_x   [NUM_COMP];
    logic [CW-1:0]      d_x;

    always_comb
    begin
        en[NS-1] = !vld_reg[NS-1] || out_ready;
        for (int k = NS - 2; k >= 0; k--)
        begin
            en[k] = !vld_reg[k] || en[k+1];
        end
    end

    assign in_ready  = en[0];
    assign out_valid = vld_reg[NS-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                vld_reg[0] <= in_valid;
            end
            for (int k = 1; k < NS; k++)
            begin
                if (en[k])
                begin
                    vld_reg[k] <= vld_reg[k-1];
                end
            end
        end
    end

    always_comb
    begin
        det_x    = EW'(det);
        det_fits = (&det_x[EW-1:DET_W-1]) || !(|det_x[EW-1:DET_W-1]);
        ad_nx    = det[DTW-1] ? -det : det;
        for (int i = 0; i < NUM_COMP; i++)
        begin
            an_nx[i] = adj[i][AW-1] ? -adj[i] : adj[i];
            nhi_x[i] = CW'(n_reg[i][NW-1:W]);
        end
        d_x = CW'(d1_reg);
    end

    // one quotient bit per stage
    always_comb
    begin
        logic [DDW:0] t;
        logic         ge;
        for (int j = 0; j < W; j++)
        begin
            for (int i = 0; i < NUM_COMP; i++)
            begin
                t            = {rem_reg[j][i], nlo_reg[j][i][W-1]};
                ge           = t >= {1'b0, d_reg[j]};
                rem_nx[j][i] = ge ? DDW'(t - {1'b0, d_reg[j]}) : t[DDW-1:0];
                q_nx[j][i]   = {q_reg[j][i][W-2:0], ge};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            ad_reg                <= ad_nx;
            fl_reg[0].singular    <= (det == '0);
            fl_reg[0].det_sat     <= !det_fits;
            fl_reg[0].ovf         <= '0;
            for (int i = 0; i < NUM_COMP; i++)
            begin
                an_reg[i]         <= an_nx[i];
                fl_reg[0].neg[i]  <= adj[i][AW-1] ^ det[DTW-1];
            end
            if (det_fits)
            begin
                det64_reg[0] <= det_x[DET_W-1:0];
            end
            else
            begin
                det64_reg[0] <= {det_x[EW-1], {(DET_W-1){!det_x[EW-1]}}};
            end
        end
        if (en[1])
        begin
            // 2|num| + |det| over 2|det| rounds half away from zero
            d1_reg       <= {ad_reg, 1'b0};
            fl_reg[1]    <= fl_reg[0];
            det64_reg[1] <= det64_reg[0];
            for (int i = 0; i < NUM_COMP; i++)
            begin
                n_reg[i] <= (NW'(an_reg[i]) << F) + NW'(ad_reg);
            end
        end
        if (en[2])
        begin
            d_reg[0]           <= d1_reg;
            fl_reg[2].singular <= fl_reg[1].singular;
            fl_reg[2].det_sat  <= fl_reg[1].det_sat;
            fl_reg[2].neg      <= fl_reg[1].neg;
            det64_reg[2]       <= det64_reg[1];
            for (int i = 0; i < NUM_COMP; i++)
            begin
                // quotient would not fit in W bits
                fl_reg[2].ovf[i] <= nhi_x[i] >= d_x;
                rem_reg[0][i]    <= nhi_x[i][DDW-1:0];
                nlo_reg[0][i]    <= n_reg[i][W-1:0];
                q_reg[0][i]      <= '0;
            end
        end
        for (int j = 0; j < W; j++)
        begin
            if (en[j+3])
            begin
                d_reg[j+1]     <= d_reg[j];
                fl_reg[j+3]    <= fl_reg[j+2];
                det64_reg[j+3] <= det64_reg[j+2];
                for (int i = 0; i < NUM_COMP; i++)
                begin
                    rem_reg[j+1][i] <= rem_nx[j][i];
                    nlo_reg[j+1][i] <= nlo_reg[j][i] << 1;
                    q_reg[j+1][i]   <= q_nx[j][i];
                end
            end
        end
    end

    assign flags   = fl_reg[NS-1];
    assign det_out = det64_reg[NS-1];
    always_comb
    begin
        for (int i = 0; i < NUM_COMP; i++)
        begin
            quot[i] = q_reg[W][i];
        end
    end

`ifndef SYNTHESIS
    a_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[NS-1] && !fl_reg[NS-1].ovf[0] |-> rem_reg[W][0] < d_reg[W])
        else $error("divider remainder not below divisor");
    a_singular_overflows: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[NS-1] && fl_reg[NS-1].singular |-> &fl_reg[NS-1].ovf)
        else $error("zero divisor did not flag overflow on every lane");
    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[NS-1] && !out_ready |=> vld_reg[NS-1])
        else $error("divider dropped a beat under stall");
`endif

endmodule

// ===== src/kst_finish.sv =====
// sign, clipping and output register
`timescale 1ns / 1ps
module kst_finish #(
    parameter int W = kst_pkg::COMP_W
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [W-1:0]                       quot [kst_pkg::NUM_COMP],
    input  kst_pkg::kst_flags_t                flags,
    input  logic [kst_pkg::DET_W-1:0]          det_in,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic signed [kst_pkg::COMP_W-1:0]  inv [kst_pkg::NUM_COMP],
    output logic signed [kst_pkg::DET_W-1:0]   det_value,
    output logic                               singular,
    output logic                               saturated
);
    import kst_pkg::*;

    localparam logic [W-1:0] MAG_MAX = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] MAG_MIN = {1'b1, {(W-1){1'b0}}};

    logic                       vld_reg;
    logic signed [COMP_W-1:0]   inv_reg [NUM_COMP];
    logic signed [DET_W-1:0]    det_reg;
    logic                       sing_reg;
    logic                       sat_reg;

    logic signed [W-1:0]        val_nx  [NUM_COMP];
    logic [NUM_COMP-1:0]        clip_nx;

    assign in_ready = !vld_reg || out_ready;

    always_comb
    begin
        for (int i = 0; i < NUM_COMP; i++)
        begin
            if (flags.neg[i])
            begin
                clip_nx[i] = flags.ovf[i] || (quot[i] > MAG_MIN);
                val_nx[i]  = clip_nx[i] ? MAG_MIN : -quot[i];
            end
            else
            begin
                clip_nx[i] = flags.ovf[i] || (quot[i] > MAG_MAX);
                val_nx[i]  = clip_nx[i] ? MAG_MAX : quot[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            vld_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready)
        begin
            sing_reg <= flags.singular;
            if (flags.singular)
            begin
                det_reg <= '0;
                sat_reg <= 1'b0;
                for (int i = 0; i < NUM_COMP; i++)
                begin
                    inv_reg[i] <= '0;
                end
            end
            else
            begin
                det_reg <= det_in;
                sat_reg <= (|clip_nx) || flags.det_sat;
                for (int i = 0; i < NUM_COMP; i++)
                begin
                    inv_reg[i] <= COMP_W'(val_nx[i]);
                end
            end
        end
    end

    assign out_valid = vld_reg;
    assign det_value = det_reg;
    assign singular  = sing_reg;
    assign saturated = sat_reg;
    always_comb
    begin
        for (int i = 0; i < NUM_COMP; i++)
        begin
            inv[i] = inv_reg[i];
        end
    end

`ifndef SYNTHESIS
    a_singular_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && singular |-> det_value == '0 && !saturated)
        else $error("singular result carries nonzero determinant or saturation");
    a_regular_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !singular |-> det_value != '0)
        else $error("regular result with zero determinant");
`endif

endmodule

// ===== src/kelvin_symmetric_tensor_inverse_top.sv =====
// Inverse and determinant of a symmetric 3x3 tensor in Kelvin notation.
//
// tensor: valid/ready beats carrying comp_0..comp_5 (xx, yy, zz, then the
//   sqrt 2 scaled xy, yz, xz terms), signed fixed point, FRAC_BITS fraction
//   bits, taken from the low min(DATA_WIDTH, 32) bits of each field.
// result: valid/ready beats with inv_0..inv_5 (same notation, saturated),
//   det_value with 2*FRAC_BITS fraction bits, singular and saturated flags.
// cfg_wr_en/cfg_wr_data write plane_mode; in plane form comp_4 and comp_5
//   are ignored and inv_4, inv_5 come out zero. Write only while idle.
// The path runs through the multiply and sum pipeline, the restoring
//   divider (one quotient bit per stage, W = min(DATA_WIDTH, 32) bits per
//   quotient) and one output register.
// Throughput is one tensor per cycle while result.ready is high.
// Reset clears all valid bits and sets plane_mode to 0.
// When the receiver stalls the last beat holds; earlier stages keep
//   filling their empty slots and tensor.ready drops once every stage holds
//   a beat. Nothing is lost or repeated.
`timescale 1ns / 1ps
module kelvin_symmetric_tensor_inverse_top #(
    parameter int FRAC_BITS  = kst_pkg::FRAC_BITS_DEF,
    parameter int DATA_WIDTH = kst_pkg::DATA_WIDTH_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_wr_en,
    input  logic       cfg_wr_data,
    kst_in_if.sink     tensor,
    kst_out_if.source  result
);
    import kst_pkg::*;

    localparam int W   = (DATA_WIDTH < COMP_W) ? DATA_WIDTH : COMP_W;
    localparam int AW  = 2 * W + 2;
    localparam int DTW = 3 * W + 4 - FRAC_BITS;

    logic                   plane_mode_reg;

    logic signed [W-1:0]    comp_in [NUM_COMP];

    logic                   fr_valid, fr_ready;
    logic signed [DTW-1:0]  fr_det;
    logic signed [AW-1:0]   fr_adj [NUM_COMP];

    logic                   dv_valid, dv_ready;
    logic [W-1:0]           dv_quot [NUM_COMP];
    kst_flags_t             dv_flags;
    logic [DET_W-1:0]       dv_det;

    logic signed [COMP_W-1:0] inv_out [NUM_COMP];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            plane_mode_reg <= 1'b0;
        end
        else if (cfg_wr_en)
        begin
            plane_mode_reg <= cfg_wr_data;
        end
    end

    assign comp_in[0] = tensor.comp_0[W-1:0];
    assign comp_in[1] = tensor.comp_1[W-1:0];
    assign comp_in[2] = tensor.comp_2[W-1:0];
    assign comp_in[3] = tensor.comp_3[W-1:0];
    assign comp_in[4] = tensor.comp_4[W-1:0];
    assign comp_in[5] = tensor.comp_5[W-1:0];

    kst_front #(
        .W (W),
        .F (FRAC_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .plane_mode (plane_mode_reg),
        .in_valid   (tensor.valid),
        .in_ready   (tensor.ready),
        .comp       (comp_in),
        .out_valid  (fr_valid),
        .out_ready  (fr_ready),
        .det        (fr_det),
        .adj        (fr_adj)
    );

    kst_divider #(
        .W (W),
        .F (FRAC_BITS)
    ) u_divider (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (fr_valid),
        .in_ready  (fr_ready),
        .det       (fr_det),
        .adj       (fr_adj),
        .out_valid (dv_valid),
        .out_ready (dv_ready),
        .quot      (dv_quot),
        .flags     (dv_flags),
        .det_out   (dv_det)
    );

    kst_finish #(
        .W (W)
    ) u_finish (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (dv_valid),
        .in_ready  (dv_ready),
        .quot      (dv_quot),
        .flags     (dv_flags),
        .det_in    (dv_det),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .inv       (inv_out),
        .det_value (result.det_value),
        .singular  (result.singular),
        .saturated (result.saturated)
    );

    assign result.inv_0 = inv_out[0];
    assign result.inv_1 = inv_out[1];
    assign result.inv_2 = inv_out[2];
    assign result.inv_3 = inv_out[3];
    assign result.inv_4 = inv_out[4];
    assign result.inv_5 = inv_out[5];

endmodule

// ===== verif/tb_kelvin_symmetric_tensor_inverse_top.sv =====
// testbench for the kelvin tensor inverse: random and directed tensors, scoreboard check
`timescale 1ns / 1ps
module tb_kelvin_symmetric_tensor_inverse_top;
    import kst_pkg::*;

    typedef logic signed [127:0] wide_t;
    typedef logic signed [COMP_W-1:0] tensor_t [NUM_COMP];

    typedef struct {
        logic signed [COMP_W-1:0] inv [NUM_COMP];
        logic signed [DET_W-1:0]  det;
        logic                     singular;
        logic                     saturated;
    } tensor_result_t;

    localparam int    LATENCY    = 42;
    localparam int    IDLE_LIMIT = 5000;
    localparam int    HOLD_LEN   = 300;
    localparam wide_t ONE_Q16    = 65536;

    class tensor_inverse_scoreboard;
        bit             plane;
        int             errors;
        tensor_result_t pending_results [$];

        function wide_t div_root2(wide_t p);
            wide_t t;
            t = p * wide_t'(64'd3037000500) + (wide_t'(1) <<< 31);
            return t >>> 32;
        endfunction

        function logic signed [COMP_W-1:0] inverse_term(wide_t adj2, wide_t det, ref bit sat);
            wide_t       num;
            wide_t       qs;
            logic [127:0] an;
            logic [127:0] ad;
            logic [127:0] q;
            bit          neg;
            num = adj2 <<< (FRAC_BITS_DEF - 1);
            neg = (num < 0) != (det < 0);
            an  = (num < 0) ? -num : num;
            ad  = (det < 0) ? -det : det;
            q   = (2 * an + ad) / (2 * ad);
            qs  = neg ? -wide_t'(q) : wide_t'(q);
            if (qs > wide_t'(32'sh7fffffff))
            begin
                sat = 1;
                return 32'sh7fffffff;
            end
            if (qs < -wide_t'(64'sh80000000))
            begin
                sat = 1;
                return 32'sh80000000;
            end
            return qs[COMP_W-1:0];
        endfunction

        function void note_tensor(tensor_t c);
            wide_t          v [NUM_COMP];
            wide_t          adj [NUM_COMP];
            wide_t          r34, r45, r35, s, det;
            tensor_result_t r;
            bit             sat;
            sat = 0;
            for (int i = 0; i < NUM_COMP; i++)
                v[i] = wide_t'(c[i]);
            if (plane)
            begin
                v[4] = 0;
                v[5] = 0;
            end
            r34 = div_root2(v[3] * v[4]);
            r45 = div_root2(v[4] * v[5]);
            r35 = div_root2(v[3] * v[5]);
            s = 2 * v[0] * v[1] * v[2] + 2 * r34 * v[5] - v[3] * v[3] * v[2]
                - v[4] * v[4] * v[0] - v[5] * v[5] * v[1];
            det = (s + ONE_Q16) >>> (FRAC_BITS_DEF + 1);
            for (int i = 0; i < NUM_COMP; i++)
                r.inv[i] = '0;
            r.det = '0;
            r.singular = 0;
            r.saturated = 0;
            if (det == 0)
                r.singular = 1;
            else
            begin
                adj[0] = 2 * v[1] * v[2] - v[4] * v[4];
                adj[1] = 2 * v[0] * v[2] - v[5] * v[5];
                adj[2] = 2 * v[0] * v[1] - v[3] * v[3];
                adj[3] = 2 * r45 - 2 * v[3] * v[2];
                adj[4] = 2 * r35 - 2 * v[4] * v[0];
                adj[5] = 2 * r34 - 2 * v[1] * v[5];
                for (int i = 0; i < NUM_COMP; i++)
                    r.inv[i] = inverse_term(adj[i], det, sat);
                if (det > wide_t'(64'sh7fffffffffffffff))
                begin
                    sat = 1;
                    r.det = 64'sh7fffffffffffffff;
                end
                else if (det < wide_t'(64'sh8000000000000000))
                begin
                    sat = 1;
                    r.det = 64'sh8000000000000000;
                end
                else
                    r.det = det[DET_W-1:0];
                r.saturated = sat;
            end
            pending_results.push_back(r);
        endfunction

        task report_mismatch(string what);
            errors++;
            $display("mismatch at %0t: %s", $time, what);
        endtask

        task check_result(tensor_result_t got);
            tensor_result_t want;
            if (pending_results.size() == 0)
            begin
                report_mismatch("result beat with nothing expected");
                return;
            end
            want = pending_results.pop_front();
            for (int i = 0; i < NUM_COMP; i++)
                if (got.inv[i] !== want.inv[i])
                    report_mismatch($sformatf("inv_%0d got %h want %h", i, got.inv[i],
                                              want.inv[i]));
            if (got.det !== want.det)
                report_mismatch($sformatf("det_value got %h want %h", got.det, want.det));
            if (got.singular !== want.singular)
                report_mismatch($sformatf("singular got %b want %b", got.singular,
                                          want.singular));
            if (got.saturated !== want.saturated)
                report_mismatch($sformatf("saturated got %b want %b", got.saturated,
                                          want.saturated));
        endtask
    endclass

    logic clk;
    logic rst_n;
    logic cfg_wr_en;
    logic cfg_wr_data;

    kst_in_if  tensor_ch ();
    kst_out_if result_ch ();

    kelvin_symmetric_tensor_inverse_top i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .tensor      (tensor_ch),
        .result      (result_ch)
    );

    tensor_inverse_scoreboard sb;
    int send_idle_pct;
    int recv_stall_pct;
    int hold_requests;
    int idle_cycles;

    initial
    begin
        clk = 0;
    end

    always #5 clk = ~clk;

    // receiver: random stalls, plus a long hold-off on request
    initial
    begin
        int hold_left;
        int hold_seen;
        hold_left = 0;
        hold_seen = 0;
        result_ch.ready = 0;
        forever
        begin
            @(negedge clk);
            if (hold_requests != hold_seen)
            begin
                hold_seen = hold_requests;
                hold_left = HOLD_LEN;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                result_ch.ready <= 0;
            end
            else
                result_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        tensor_result_t got;
        tensor_t        c;
        if (rst_n && tensor_ch.valid && tensor_ch.ready)
        begin
            c[0] = tensor_ch.comp_0;
            c[1] = tensor_ch.comp_1;
            c[2] = tensor_ch.comp_2;
            c[3] = tensor_ch.comp_3;
            c[4] = tensor_ch.comp_4;
            c[5] = tensor_ch.comp_5;
            sb.note_tensor(c);
        end
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            got.inv[0] = result_ch.inv_0;
            got.inv[1] = result_ch.inv_1;
            got.inv[2] = result_ch.inv_2;
            got.inv[3] = result_ch.inv_3;
            got.inv[4] = result_ch.inv_4;
            got.inv[5] = result_ch.inv_5;
            got.det = result_ch.det_value;
            got.singular = result_ch.singular;
            got.saturated = result_ch.saturated;
            sb.check_result(got);
        end
        if ((tensor_ch.valid && tensor_ch.ready) || (result_ch.valid && result_ch.ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // one tensor beat; valid stays high on return, the next call decides
    task send_tensor(tensor_t c);
        while ($urandom_range(99) < send_idle_pct)
        begin
            tensor_ch.valid <= 0;
            @(negedge clk);
        end
        tensor_ch.valid  <= 1;
        tensor_ch.comp_0 <= c[0];
        tensor_ch.comp_1 <= c[1];
        tensor_ch.comp_2 <= c[2];
        tensor_ch.comp_3 <= c[3];
        tensor_ch.comp_4 <= c[4];
        tensor_ch.comp_5 <= c[5];
        do
            @(posedge clk);
        while (!tensor_ch.ready);
        @(negedge clk);
    endtask

    task drain_results;
        tensor_ch.valid <= 0;
        while (sb.pending_results.size() != 0)
            @(negedge clk);
    endtask

    task write_plane_mode(bit mode);
        drain_results();
        repeat (LATENCY + 8) @(negedge clk);
        cfg_wr_en   <= 1;
        cfg_wr_data <= mode;
        sb.plane = mode;
        @(negedge clk);
        cfg_wr_en <= 0;
    endtask

    function logic signed [COMP_W-1:0] pick_value(int kind);
        case (kind)
            0: return $urandom;
            1: return 32'sh00010000 * $signed($urandom_range(8)) - 32'sh00040000
                      + $signed($urandom_range(16'hffff));
            2: return $urandom_range(3) == 0 ? 32'sh7fffffff : 32'sh80000000;
            default: return $signed($urandom_range(32)) - 16;
        endcase
    endfunction

    function tensor_t random_tensor();
        tensor_t c;
        int      kind;
        kind = $urandom_range(9);
        for (int i = 0; i < NUM_COMP; i++)
        begin
            if (kind < 5)
                c[i] = pick_value(1);
            else if (kind < 7)
                c[i] = pick_value(0);
            else
                c[i] = pick_value($urandom_range(3));
        end
        // well-conditioned diagonal so most tensors invert cleanly
        if (kind < 3)
            for (int i = 0; i < 3; i++)
                c[i] = 32'sh00040000 + $signed($urandom_range(20'hfffff));
        // singular: one row and column zero
        if (kind == 9)
        begin
            c[0] = 0;
            c[3] = 0;
            c[5] = 0;
        end
        return c;
    endfunction

    task run_random(int count, int idle_pct, int stall_pct, bit with_hold, bit with_pause);
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        for (int n = 0; n < count; n++)
        begin
            if (with_hold && n == 10)
                hold_requests++;
            if (with_pause && n == count / 2)
                drain_results();
            send_tensor(random_tensor());
        end
    endtask

    task run_directed;
        tensor_t c;
        logic signed [COMP_W-1:0] pat [12][NUM_COMP];
        pat[0]  = '{32'sh10000, 32'sh10000, 32'sh10000, 0, 0, 0};
        pat[1]  = '{0, 0, 0, 0, 0, 0};
        pat[2]  = '{32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff,
                    32'sh7fffffff, 32'sh7fffffff};
        pat[3]  = '{32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sh80000000,
                    32'sh80000000, 32'sh80000000};
        pat[4]  = '{32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 0, 0, 0};
        pat[5]  = '{1, 1, 1, 0, 0, 0};
        pat[6]  = '{32'sh20000, 32'sh30000, 32'sh40000, 32'sh16a0a, -32'sh0b505, 32'sh0b505};
        pat[7]  = '{-32'sh20000, 32'sh30000, -32'sh40000, -32'sh10000, 32'sh10000, -32'sh8000};
        pat[8]  = '{32'sh10000, 32'sh10000, 32'sh10000, 32'sh16a0a, 0, 0};
        pat[9]  = '{32'sh80000000, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff,
                    32'sh80000000, 32'sh7fffffff};
        pat[10] = '{32'sh10000, 0, 32'sh10000, 0, 32'sh10000, 32'sh10000};
        pat[11] = '{-1, -1, -1, -1, -1, -1};
        send_idle_pct = 0;
        recv_stall_pct = 0;
        for (int n = 0; n < 12; n++)
        begin
            for (int i = 0; i < NUM_COMP; i++)
                c[i] = pat[n][i];
            send_tensor(c);
        end
    endtask

    initial
    begin
        sb = new();
        sb.plane = 0;
        sb.errors = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_requests = 0;
        idle_cycles = 0;
        rst_n = 0;
        cfg_wr_en = 0;
        cfg_wr_data = 0;
        tensor_ch.valid = 0;
        tensor_ch.comp_0 = 0;
        tensor_ch.comp_1 = 0;
        tensor_ch.comp_2 = 0;
        tensor_ch.comp_3 = 0;
        tensor_ch.comp_4 = 0;
        tensor_ch.comp_5 = 0;
        repeat (6) @(negedge clk);
        rst_n <= 1;
        @(negedge clk);

        run_directed();
        write_plane_mode(1);
        run_directed();
        write_plane_mode(0);
        run_random(170, 0, 0, 1, 0);
        run_random(150, 65, 0, 0, 1);
        write_plane_mode(1);
        run_random(150, 0, 65, 0, 0);
        run_random(150, 12, 12, 1, 1);
        write_plane_mode(0);
        run_random(150, 65, 65, 0, 0);
        run_random(150, 0, 0, 0, 0);

        drain_results();
        repeat (LATENCY + 8) @(negedge clk);
        if (sb.errors == 0 && sb.pending_results.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
